// File: rtl/mjs_pkg.sv
// ----------------------------------------------------------------------------
// Multiprocessor job scheduler package
// Shared sizes, policy and register codes, beat types and sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mjs_pkg;

    localparam int MAX_JOBS   = 16;
    localparam int PROCESSORS = 5;
    localparam int SLOT_W     = $clog2(MAX_JOBS);
    localparam int LEN_W      = $clog2(MAX_JOBS + 1);
    localparam int RUN_W      = $clog2(PROCESSORS + 1);
    localparam int NEED_W     = 8;
    localparam int WAIT_W     = 16;
    localparam int DIVD_W     = WAIT_W + 1;
    localparam int SCORE_W    = DIVD_W + 1;
    localparam int DCNT_W     = $clog2(DIVD_W);
    localparam int CFG_DATA_W = 4;

    localparam logic [2:0] POL_NP_SJF  = 3'd0;
    localparam logic [2:0] POL_NP_HRRN = 3'd1;
    localparam logic [2:0] POL_P_SJF   = 3'd2;
    localparam logic [2:0] POL_P_HRRN  = 3'd3;
    localparam logic [2:0] POL_RR      = 3'd4;

    localparam logic CFG_POLICY  = 1'b0;
    localparam logic CFG_QUANTUM = 1'b1;

    typedef struct packed {
        logic              new_valid;
        logic [NEED_W-1:0] new_service_time;
    } in_beat_t;

    typedef struct packed {
        logic        accepted;
        logic [3:0]  new_slot;
        logic [15:0] running_mask;
        logic [15:0] finished_mask;
        logic [4:0]  ready_count;
        logic        all_done;
    } out_beat_t;

    typedef enum logic [14:0] {
        S_IDLE     = 15'b000000000000001,
        S_SCHED    = 15'b000000000000010,
        S_FETCH    = 15'b000000000000100,
        S_KEY      = 15'b000000000001000,
        S_DIV      = 15'b000000000010000,
        S_SCAN     = 15'b000000000100000,
        S_DISP     = 15'b000000001000000,
        S_FILL     = 15'b000000010000000,
        S_PAIR_A   = 15'b000000100000000,
        S_PAIR_B   = 15'b000001000000000,
        S_AGE      = 15'b000010000000000,
        S_AGE_WR   = 15'b000100000000000,
        S_SERVE    = 15'b001000000000000,
        S_SERVE_WR = 15'b010000000000000,
        S_FINISH   = 15'b100000000000000
    } seq_state_t;

endpackage

`default_nettype wire

// File: rtl/multiprocessor_job_scheduler.sv
// ----------------------------------------------------------------------------
// Multiprocessor job scheduler
// One input beat is one scheduler tick, optionally with a new job; one
// output beat reports the tick.
//
// Channels: in (valid/ready, in_beat_t), out (valid/ready, out_beat_t) and a
// configuration write channel (cfg_index 0 policy, 1 quantum), always ready.
// Job need and served time sit in one RAM, waited time in a second; the
// sequencer reads, updates and writes back one slot at a time.
// Each tick ages every ready job and serves every running job. Scheduling
// scans the ready jobs and dispatches the best in non-preemptive modes; the
// preemptive modes fill free processors and compare each ready/running
// pair. Ratio policies run a 17-step shift-subtract divider for each
// fetched job with nonzero need.
// One tick is in flight at a time; the next input beat is taken once the
// result sits in the output register. If the receiver stalls, the result
// holds there and the following tick stops before its own result.
// Reset empties both queues, clears counters, sets policy 0, quantum 2.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module multiprocessor_job_scheduler (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire mjs_pkg::in_beat_t             in_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output mjs_pkg::out_beat_t                 out_data,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic                          cfg_index,
    input  wire logic [mjs_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int SW = mjs_pkg::SLOT_W;
    localparam int LW = mjs_pkg::LEN_W;
    localparam int RW = mjs_pkg::RUN_W;
    localparam int NW = mjs_pkg::NEED_W;
    localparam int WW = mjs_pkg::WAIT_W;
    localparam int DW = mjs_pkg::DIVD_W;
    localparam int KW = mjs_pkg::SCORE_W;
    localparam int CW = mjs_pkg::DCNT_W;
    localparam int NJ = mjs_pkg::MAX_JOBS;
    localparam int NP = mjs_pkg::PROCESSORS;

    mjs_pkg::seq_state_t state_reg, state_next, ret_reg, ret_next;

    logic [SW-1:0] fifo_reg [NJ];
    logic [SW-1:0] fifo_next [NJ];
    logic [SW-1:0] run_reg [NP];
    logic [SW-1:0] run_next [NP];
    logic [LW-1:0] ready_len_reg, ready_len_next;
    logic [RW-1:0] run_len_reg, run_len_next;
    logic [LW-1:0] created_reg, created_next;
    logic [3:0]    phase_reg, phase_next;
    logic          refused_reg, refused_next;
    logic [2:0]    policy_reg;
    logic [3:0]    quantum_reg;
    logic [LW-1:0] idx_reg, idx_next;
    logic [RW-1:0] j_reg, j_next;
    logic [RW-1:0] wr_reg, wr_next;
    logic [SW-1:0] best_reg, best_next;
    logic [KW-1:0] best_score_reg, best_score_next;
    logic          found_reg, found_next;
    logic [KW-1:0] score_a_reg, score_a_next;
    logic [KW-1:0] key_reg, key_next;
    logic [SW-1:0] fetch_reg, fetch_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [NW-1:0] rem_reg, rem_next;
    logic [NW-1:0] dneed_reg, dneed_next;
    logic [CW-1:0] dcnt_reg, dcnt_next;
    logic          accepted_reg, accepted_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic [15:0]   fin_reg, fin_next;
    logic          out_valid_reg, out_valid_next;
    mjs_pkg::out_beat_t out_data_reg, out_data_next;

    logic               ns_we, w_we;
    logic [SW-1:0]      ns_waddr, w_waddr, raddr;
    logic [2*NW-1:0]    ns_wdata, ns_rdata;
    logic [WW-1:0]      w_wdata, w_rdata;

    mjs_ram #(.WIDTH(2 * NW), .DEPTH(NJ)) u_ns_ram (
        .clk   (clk),
        .we    (ns_we),
        .waddr (ns_waddr),
        .wdata (ns_wdata),
        .raddr (raddr),
        .rdata (ns_rdata)
    );

    mjs_ram #(.WIDTH(WW), .DEPTH(NJ)) u_w_ram (
        .clk   (clk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (w_wdata),
        .raddr (raddr),
        .rdata (w_rdata)
    );

    assign in_ready  = (state_reg == mjs_pkg::S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        logic          ratio_mode;
        logic [NW-1:0] need;
        logic [NW-1:0] served;
        logic [NW-1:0] served_inc;
        logic [8:0]    rem9;
        logic [8:0]    rem_sh;
        logic          ge;
        logic [DW-1:0] quo_new;
        logic [SW-1:0] dslot;
        logic [SW-1:0] qslot;
        logic [LW:0]   phase_inc;
        logic [3:0]    qeff;
        logic [15:0]   rmask;
        state_next      = state_reg;
        ret_next        = ret_reg;
        fifo_next       = fifo_reg;
        run_next        = run_reg;
        ready_len_next  = ready_len_reg;
        run_len_next    = run_len_reg;
        created_next    = created_reg;
        phase_next      = phase_reg;
        refused_next    = refused_reg;
        idx_next        = idx_reg;
        j_next          = j_reg;
        wr_next         = wr_reg;
        best_next       = best_reg;
        best_score_next = best_score_reg;
        found_next      = found_reg;
        score_a_next    = score_a_reg;
        key_next        = key_reg;
        fetch_next      = fetch_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        dneed_next      = dneed_reg;
        dcnt_next       = dcnt_reg;
        accepted_next   = accepted_reg;
        slot_next       = slot_reg;
        fin_next        = fin_reg;
        out_valid_next  = out_valid_reg & ~out_ready;
        out_data_next   = out_data_reg;
        ns_we           = 1'b0;
        ns_waddr        = fetch_reg;
        ns_wdata        = '0;
        w_we            = 1'b0;
        w_waddr         = fetch_reg;
        w_wdata         = '0;
        raddr           = fetch_reg;
        ratio_mode      = (policy_reg == mjs_pkg::POL_NP_HRRN)
                        || (policy_reg == mjs_pkg::POL_P_HRRN);
        need            = ns_rdata[2*NW-1:NW];
        served          = ns_rdata[NW-1:0];
        served_inc      = (served == '1) ? served : served + 1'b1;
        rem9            = 9'(9'd255 - {1'b0, need}) + {1'b0, served};
        rem_sh          = {rem_reg, quo_reg[DW-1]};
        ge              = rem_sh >= {1'b0, dneed_reg};
        quo_new         = {quo_reg[DW-2:0], ge};
        dslot           = fifo_reg[0];
        qslot           = run_reg[0];
        phase_inc       = {2'b0, phase_reg} + 1'b1;
        qeff            = (quantum_reg == 4'd0) ? 4'd1 : quantum_reg;
        rmask           = '0;

        unique case (state_reg)
            mjs_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    accepted_next = 1'b0;
                    slot_next     = '0;
                    fin_next      = '0;
                    if (in_data.new_valid)
                    begin
                        if (created_reg < LW'(NJ))
                        begin
                            ns_we    = 1'b1;
                            ns_waddr = created_reg[SW-1:0];
                            ns_wdata = {in_data.new_service_time, NW'(0)};
                            w_we     = 1'b1;
                            w_waddr  = created_reg[SW-1:0];
                            w_wdata  = '0;
                            fifo_next[ready_len_reg[SW-1:0]] = created_reg[SW-1:0];
                            ready_len_next = ready_len_reg + 1'b1;
                            created_next   = created_reg + 1'b1;
                            accepted_next  = 1'b1;
                            slot_next      = created_reg[SW-1:0];
                            refused_next   = 1'b0;
                        end
                        else
                        begin
                            refused_next = 1'b1;
                        end
                    end
                    state_next = mjs_pkg::S_SCHED;
                end
            end

            mjs_pkg::S_SCHED:
            begin
                idx_next   = '0;
                state_next = mjs_pkg::S_AGE;
                priority if (policy_reg == mjs_pkg::POL_NP_SJF
                             || policy_reg == mjs_pkg::POL_NP_HRRN)
                begin
                    if (ready_len_reg != '0)
                    begin
                        found_next = 1'b0;
                        fetch_next = fifo_reg[0];
                        ret_next   = mjs_pkg::S_SCAN;
                        state_next = mjs_pkg::S_FETCH;
                    end
                end
                else if (policy_reg == mjs_pkg::POL_P_SJF
                         || policy_reg == mjs_pkg::POL_P_HRRN)
                begin
                    state_next = mjs_pkg::S_FILL;
                end
                else if (policy_reg == mjs_pkg::POL_RR)
                begin
                    if (phase_reg == 4'd0)
                    begin
                        for (int k = 0; k < NP; k++)
                        begin
                            if (RW'(k) < run_len_reg)
                            begin
                                fifo_next[SW'(ready_len_reg + LW'(k))] = run_reg[k];
                            end
                        end
                        ready_len_next = ready_len_reg + LW'(run_len_reg);
                        run_len_next   = '0;
                        state_next     = mjs_pkg::S_FILL;
                    end
                end
            end

            mjs_pkg::S_FETCH:
            begin
                raddr      = fetch_reg;
                state_next = mjs_pkg::S_KEY;
            end

            mjs_pkg::S_KEY:
            begin
                state_next = ret_reg;
                if (ratio_mode)
                begin
                    if (need == '0)
                    begin
                        key_next = '1;
                    end
                    else
                    begin
                        quo_next   = {1'b0, w_rdata} + DW'(need);
                        rem_next   = '0;
                        dneed_next = need;
                        dcnt_next  = '0;
                        state_next = mjs_pkg::S_DIV;
                    end
                end
                else if (policy_reg == mjs_pkg::POL_NP_SJF)
                begin
                    key_next = KW'(~need);
                end
                else
                begin
                    key_next = KW'(rem9);
                end
            end

            mjs_pkg::S_DIV:
            begin
                rem_next  = ge ? NW'(rem_sh - {1'b0, dneed_reg}) : rem_sh[NW-1:0];
                quo_next  = quo_new;
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == CW'(DW - 1))
                begin
                    key_next   = {1'b0, quo_new};
                    state_next = ret_reg;
                end
            end

            mjs_pkg::S_SCAN:
            begin
                if (!found_reg || key_reg > best_score_reg)
                begin
                    best_score_next = key_reg;
                    best_next       = idx_reg[SW-1:0];
                    found_next      = 1'b1;
                end
                if (idx_reg + 1'b1 < ready_len_reg)
                begin
                    idx_next   = idx_reg + 1'b1;
                    fetch_next = fifo_reg[SW'(idx_reg + 1'b1)];
                    state_next = mjs_pkg::S_FETCH;
                end
                else
                begin
                    state_next = mjs_pkg::S_DISP;
                end
            end

            mjs_pkg::S_DISP:
            begin
                if (run_len_reg < RW'(NP))
                begin
                    dslot = fifo_reg[best_reg];
                    for (int k = 0; k < NJ - 1; k++)
                    begin
                        if (SW'(k) >= best_reg)
                        begin
                            fifo_next[k] = fifo_reg[k + 1];
                        end
                    end
                    ready_len_next         = ready_len_reg - 1'b1;
                    run_next[run_len_reg]  = dslot;
                    run_len_next           = run_len_reg + 1'b1;
                    w_we                   = 1'b1;
                    w_waddr                = dslot;
                    w_wdata                = '0;
                end
                idx_next   = '0;
                state_next = mjs_pkg::S_AGE;
            end

            mjs_pkg::S_FILL:
            begin
                if (ready_len_reg != '0 && run_len_reg < RW'(NP))
                begin
                    for (int k = 0; k < NJ - 1; k++)
                    begin
                        fifo_next[k] = fifo_reg[k + 1];
                    end
                    ready_len_next        = ready_len_reg - 1'b1;
                    run_next[run_len_reg] = dslot;
                    run_len_next          = run_len_reg + 1'b1;
                    w_we                  = 1'b1;
                    w_waddr               = dslot;
                    w_wdata               = '0;
                end
                else if (policy_reg != mjs_pkg::POL_RR
                         && ready_len_reg != '0 && run_len_reg != '0)
                begin
                    idx_next   = '0;
                    j_next     = '0;
                    fetch_next = fifo_reg[0];
                    ret_next   = mjs_pkg::S_PAIR_A;
                    state_next = mjs_pkg::S_FETCH;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = mjs_pkg::S_AGE;
                end
            end

            mjs_pkg::S_PAIR_A:
            begin
                score_a_next = key_reg;
                fetch_next   = run_reg[j_reg];
                ret_next     = mjs_pkg::S_PAIR_B;
                state_next   = mjs_pkg::S_FETCH;
            end

            mjs_pkg::S_PAIR_B:
            begin
                if (score_a_reg > key_reg)
                begin
                    dslot                       = fifo_reg[idx_reg[SW-1:0]];
                    qslot                       = run_reg[j_reg];
                    fifo_next[idx_reg[SW-1:0]]  = qslot;
                    run_next[j_reg]             = dslot;
                    w_we                        = 1'b1;
                    w_waddr                     = dslot;
                    w_wdata                     = '0;
                    score_a_next                = key_reg;
                end
                if (j_reg + 1'b1 < run_len_reg)
                begin
                    j_next     = j_reg + 1'b1;
                    fetch_next = run_reg[RW'(j_reg + 1'b1)];
                    ret_next   = mjs_pkg::S_PAIR_B;
                    state_next = mjs_pkg::S_FETCH;
                end
                else if (idx_reg + 1'b1 < ready_len_reg)
                begin
                    idx_next   = idx_reg + 1'b1;
                    j_next     = '0;
                    fetch_next = fifo_reg[SW'(idx_reg + 1'b1)];
                    ret_next   = mjs_pkg::S_PAIR_A;
                    state_next = mjs_pkg::S_FETCH;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = mjs_pkg::S_AGE;
                end
            end

            mjs_pkg::S_AGE:
            begin
                if (idx_reg < ready_len_reg)
                begin
                    raddr      = fifo_reg[idx_reg[SW-1:0]];
                    state_next = mjs_pkg::S_AGE_WR;
                end
                else
                begin
                    j_next     = '0;
                    wr_next    = '0;
                    state_next = mjs_pkg::S_SERVE;
                end
            end

            mjs_pkg::S_AGE_WR:
            begin
                w_we       = 1'b1;
                w_waddr    = fifo_reg[idx_reg[SW-1:0]];
                w_wdata    = (w_rdata == '1) ? w_rdata : w_rdata + 1'b1;
                idx_next   = idx_reg + 1'b1;
                state_next = mjs_pkg::S_AGE;
            end

            mjs_pkg::S_SERVE:
            begin
                if (j_reg < run_len_reg)
                begin
                    raddr      = run_reg[j_reg];
                    state_next = mjs_pkg::S_SERVE_WR;
                end
                else
                begin
                    run_len_next = wr_reg;
                    state_next   = mjs_pkg::S_FINISH;
                end
            end

            mjs_pkg::S_SERVE_WR:
            begin
                qslot    = run_reg[j_reg];
                ns_we    = 1'b1;
                ns_waddr = qslot;
                ns_wdata = {need, served_inc};
                if (served_inc >= need)
                begin
                    fin_next = fin_reg | (16'd1 << qslot);
                end
                else
                begin
                    run_next[wr_reg] = qslot;
                    wr_next          = wr_reg + 1'b1;
                end
                j_next     = j_reg + 1'b1;
                state_next = mjs_pkg::S_SERVE;
            end

            mjs_pkg::S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    for (int k = 0; k < NP; k++)
                    begin
                        if (RW'(k) < run_len_reg)
                        begin
                            rmask = rmask | (16'd1 << run_reg[k]);
                        end
                    end
                    out_data_next.accepted      = accepted_reg;
                    out_data_next.new_slot      = 4'(slot_reg);
                    out_data_next.running_mask  = rmask;
                    out_data_next.finished_mask = fin_reg;
                    out_data_next.ready_count   = 5'(ready_len_reg);
                    out_data_next.all_done      = refused_reg && ready_len_reg == '0
                                                && run_len_reg == '0;
                    out_valid_next              = 1'b1;
                    phase_next = (phase_inc >= {2'b0, qeff}) ? 4'd0 : phase_inc[3:0];
                    state_next = mjs_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = mjs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mjs_pkg::S_IDLE;
            ret_reg       <= mjs_pkg::S_IDLE;
            ready_len_reg <= '0;
            run_len_reg   <= '0;
            created_reg   <= '0;
            phase_reg     <= '0;
            refused_reg   <= 1'b0;
            policy_reg    <= mjs_pkg::POL_NP_SJF;
            quantum_reg   <= 4'd2;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            ready_len_reg <= ready_len_next;
            run_len_reg   <= run_len_next;
            created_reg   <= created_next;
            phase_reg     <= phase_next;
            refused_reg   <= refused_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == mjs_pkg::CFG_POLICY)
                begin
                    policy_reg <= cfg_data[2:0];
                end
                else
                begin
                    quantum_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fifo_reg       <= fifo_next;
        run_reg        <= run_next;
        idx_reg        <= idx_next;
        j_reg          <= j_next;
        wr_reg         <= wr_next;
        best_reg       <= best_next;
        best_score_reg <= best_score_next;
        found_reg      <= found_next;
        score_a_reg    <= score_a_next;
        key_reg        <= key_next;
        fetch_reg      <= fetch_next;
        quo_reg        <= quo_next;
        rem_reg        <= rem_next;
        dneed_reg      <= dneed_next;
        dcnt_reg       <= dcnt_next;
        accepted_reg   <= accepted_next;
        slot_reg       <= slot_next;
        fin_reg        <= fin_next;
        out_data_reg   <= out_data_next;
    end

endmodule

`default_nettype wire

// File: rtl/mjs_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mjs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// Multiprocessor job scheduler testbench
// Feeds scheduler ticks, some carrying new jobs, through every policy and
// several quantum settings, predicts each tick's report and checks it field
// by field. Sender and receiver idle at random, in turns and then both at
// once, and one long receiver hold fills the block up and stalls its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import mjs_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int LONG_HOLD      = 400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_beat_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_beat_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = 1'b0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    multiprocessor_job_scheduler u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // scheduler model state
    logic [7:0]  job_need [MAX_JOBS];
    logic [7:0]  job_served [MAX_JOBS];
    logic [15:0] job_waited [MAX_JOBS];
    logic [15:0] job_turn [MAX_JOBS];
    logic [3:0]  ready_q [MAX_JOBS];
    logic [3:0]  run_q [PROCESSORS];
    int          ready_n = 0;
    int          run_n = 0;
    int          jobs_made = 0;
    int          phase_cnt = 0;
    bit          last_refused = 0;
    logic [2:0]  cur_policy = POL_NP_SJF;
    logic [3:0]  cur_quantum = 4'd2;

    in_beat_t  tick_q [$];
    out_beat_t report_q [$];
    int in_idle_pct = 0;
    int out_stall_pct = 0;
    int hold_reqs = 0;
    int hold_done = 0;
    int hold_cnt = 0;
    int errors = 0;
    int reports_checked = 0;
    int jobs_retired = 0;
    int idle_cycles = 0;

    function automatic logic [31:0] ratio_of(input logic [3:0] s);
        if (job_need[s] == 0)
            return 32'hFFFF_FFFF;
        return (32'(job_waited[s]) + 32'(job_need[s])) / 32'(job_need[s]);
    endfunction

    function automatic int remain_of(input logic [3:0] s);
        return int'(job_need[s]) - int'(job_served[s]);
    endfunction

    function automatic void dispatch(input int pos);
        logic [3:0] s;
        if (pos >= ready_n || run_n >= PROCESSORS)
            return;
        s = ready_q[pos];
        for (int k = pos; k + 1 < ready_n; k++)
            ready_q[k] = ready_q[k + 1];
        ready_n--;
        run_q[run_n] = s;
        run_n++;
        job_waited[s] = '0;
    endfunction

    function automatic void swap_in(input int i, input int j);
        logic [3:0] r;
        r = ready_q[i];
        job_waited[r] = '0;
        ready_q[i] = run_q[j];
        run_q[j] = r;
    endfunction

    function automatic void schedule_tick();
        int best;
        bit found;
        int mn;
        logic [31:0] mx;
        logic [31:0] ri;
        best = 0;
        found = 0;
        case (cur_policy)
            POL_NP_SJF:
            begin
                mn = 32'h7FFF_FFFF;
                for (int i = 0; i < ready_n; i++)
                    if (int'(job_need[ready_q[i]]) < mn)
                    begin
                        mn = job_need[ready_q[i]];
                        best = i;
                        found = 1;
                    end
                if (found)
                    dispatch(best);
            end
            POL_NP_HRRN:
            begin
                mx = 0;
                for (int i = 0; i < ready_n; i++)
                    if (ratio_of(ready_q[i]) > mx)
                    begin
                        mx = ratio_of(ready_q[i]);
                        best = i;
                        found = 1;
                    end
                if (found)
                    dispatch(best);
            end
            POL_P_SJF:
            begin
                while (ready_n > 0 && run_n < PROCESSORS)
                    dispatch(0);
                for (int i = 0; i < ready_n; i++)
                    for (int j = 0; j < run_n; j++)
                        if (remain_of(ready_q[i]) < remain_of(run_q[j]))
                            swap_in(i, j);
            end
            POL_P_HRRN:
            begin
                while (ready_n > 0 && run_n < PROCESSORS)
                    dispatch(0);
                for (int i = 0; i < ready_n; i++)
                begin
                    ri = ratio_of(ready_q[i]);
                    for (int j = 0; j < run_n; j++)
                        if (ri > ratio_of(run_q[j]))
                        begin
                            swap_in(i, j);
                            ri = ratio_of(ready_q[i]);
                        end
                end
            end
            POL_RR:
            begin
                if (phase_cnt == 0)
                begin
                    for (int j = 0; j < run_n; j++)
                        if (ready_n < MAX_JOBS)
                        begin
                            ready_q[ready_n] = run_q[j];
                            ready_n++;
                        end
                    run_n = 0;
                    while (ready_n > 0 && run_n < PROCESSORS)
                        dispatch(0);
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic out_beat_t predict_tick(input in_beat_t b);
        out_beat_t r;
        int keep;
        int q;
        logic [3:0] s;
        r = '0;
        if (b.new_valid)
        begin
            if (jobs_made < MAX_JOBS)
            begin
                s = 4'(jobs_made);
                jobs_made++;
                job_need[s] = b.new_service_time;
                job_served[s] = '0;
                job_waited[s] = '0;
                job_turn[s] = '0;
                ready_q[ready_n] = s;
                ready_n++;
                r.accepted = 1'b1;
                r.new_slot = s;
                last_refused = 0;
            end
            else
                last_refused = 1;
        end
        schedule_tick();
        for (int i = 0; i < ready_n; i++)
        begin
            s = ready_q[i];
            if (job_waited[s] != 16'hFFFF) job_waited[s]++;
            if (job_turn[s] != 16'hFFFF) job_turn[s]++;
        end
        for (int j = 0; j < run_n; j++)
        begin
            s = run_q[j];
            if (job_served[s] != 8'hFF) job_served[s]++;
            if (job_turn[s] != 16'hFFFF) job_turn[s]++;
        end
        keep = 0;
        for (int j = 0; j < run_n; j++)
        begin
            s = run_q[j];
            if (job_served[s] >= job_need[s])
                r.finished_mask[s] = 1'b1;
            else
            begin
                run_q[keep] = s;
                keep++;
            end
        end
        run_n = keep;
        q = (cur_quantum == 0) ? 1 : cur_quantum;
        phase_cnt = (phase_cnt + 1 >= q) ? 0 : phase_cnt + 1;
        for (int j = 0; j < run_n; j++)
            r.running_mask[run_q[j]] = 1'b1;
        r.ready_count = 5'(ready_n);
        r.all_done = last_refused && ready_n == 0 && run_n == 0;
        return r;
    endfunction

    // driver: offer ticks, predict on every accepted beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                report_q = {report_q, predict_tick(in_data)};
            if (!in_valid || in_ready)
            begin
                if (tick_q.size() > 0 && $urandom_range(99) >= in_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data <= tick_q.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: back-pressure and compare
    always @(posedge clk)
    begin
        out_beat_t exp_r;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (report_q.size() == 0)
                begin
                    $display("%0t: unexpected beat %h", $time, out_data);
                    errors++;
                end
                else
                begin
                    exp_r = report_q.pop_front();
                    reports_checked++;
                    jobs_retired += $countones(out_data.finished_mask);
                    if (exp_r.accepted !== out_data.accepted)
                        $display("%0t: accepted exp %h got %h", $time,
                                 exp_r.accepted, out_data.accepted);
                    if (exp_r.new_slot !== out_data.new_slot)
                        $display("%0t: new_slot exp %h got %h", $time,
                                 exp_r.new_slot, out_data.new_slot);
                    if (exp_r.running_mask !== out_data.running_mask)
                        $display("%0t: running_mask exp %h got %h", $time,
                                 exp_r.running_mask, out_data.running_mask);
                    if (exp_r.finished_mask !== out_data.finished_mask)
                        $display("%0t: finished_mask exp %h got %h", $time,
                                 exp_r.finished_mask, out_data.finished_mask);
                    if (exp_r.ready_count !== out_data.ready_count)
                        $display("%0t: ready_count exp %h got %h", $time,
                                 exp_r.ready_count, out_data.ready_count);
                    if (exp_r.all_done !== out_data.all_done)
                        $display("%0t: all_done exp %h got %h", $time,
                                 exp_r.all_done, out_data.all_done);
                    if (exp_r !== out_data)
                        errors++;
                end
            end
            if (hold_reqs != hold_done)
            begin
                hold_done <= hold_reqs;
                hold_cnt <= LONG_HOLD;
                out_ready <= 1'b0;
            end
            else if (hold_cnt > 0)
            begin
                hold_cnt <= hold_cnt - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= $urandom_range(99) >= out_stall_pct;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired", $time);
                $display("** multiprocessor_job_scheduler: FAILED **");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic drain();
        while (tick_q.size() > 0 || report_q.size() > 0 || in_valid)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [3:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_POLICY)
            cur_policy = val[2:0];
        else
            cur_quantum = val;
    endtask

    task automatic add_tick(input bit v, input logic [7:0] svc);
        in_beat_t b;
        b.new_valid = v;
        b.new_service_time = svc;
        tick_q = {tick_q, b};
    endtask

    logic [2:0] phase_pol [10] = '{POL_NP_SJF, POL_NP_HRRN, POL_P_SJF, POL_P_HRRN,
                                   POL_RR, POL_RR, POL_RR, 3'd5, POL_P_HRRN, 3'd7};
    logic [3:0] phase_qnt [10] = '{4'd2, 4'd15, 4'd1, 4'd7, 4'd0, 4'd1, 4'd15,
                                   4'd3, 4'd2, 4'd9};

    initial
    begin
        logic [7:0] svc;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes of service time, idle ticks with noise
        write_reg(CFG_POLICY, {1'b0, POL_P_SJF});
        add_tick(1, 8'd0);
        add_tick(1, 8'd1);
        add_tick(1, 8'd255);
        add_tick(0, 8'hAA);
        add_tick(1, 8'd2);
        add_tick(0, 8'h55);
        add_tick(1, 8'd254);
        add_tick(0, 8'hFF);
        add_tick(1, 8'd3);
        add_tick(0, 8'h00);
        for (int k = 0; k < 10; k++)
            add_tick(0, 8'($urandom));
        drain();

        for (int p = 0; p < 10; p++)
        begin
            write_reg(CFG_POLICY, {1'b0, phase_pol[p]});
            write_reg(CFG_QUANTUM, phase_qnt[p]);
            in_idle_pct = (p % 4 == 1 || p % 4 == 3) ? (p % 4 == 1 ? 78 : 14) : 0;
            out_stall_pct = (p % 4 == 2) ? 78 : (p % 4 == 3 ? 14 : 0);
            if (p == 3)
                hold_reqs++;
            for (int k = 0; k < 178; k++)
            begin
                case ($urandom_range(3))
                    0: svc = 8'($urandom_range(1, 255));
                    default: svc = 8'($urandom_range(1, 60));
                endcase
                add_tick($urandom_range(99) == 0, svc);
            end
            drain();
        end

        repeat (60) @(posedge clk);
        if (report_q.size() != 0)
            errors++;
        $display("Checked %0d tick reports, %0d jobs created, %0d retired,",
                 reports_checked, jobs_made, jobs_retired);
        $display("over all policies and quantum settings incl. undefined codes.");
        if (errors == 0)
            $display("** multiprocessor_job_scheduler: PASSED **");
        else
            $display("** multiprocessor_job_scheduler: FAILED **");
        $finish;
    end

endmodule

// File: files.f
rtl/mjs_pkg.sv
rtl/mjs_ram.sv
rtl/multiprocessor_job_scheduler.sv
sim/testbench.sv
